// ===== hdl/dspr_pkg.sv =====
// dspr_pkg: constants and helpers shared by the dual stream pcg range unit
// no dependencies
`timescale 1ns / 1ps

package dspr_pkg;

   // request operation codes
   localparam logic OP_RESEED = 1'b0;
   localparam logic OP_DRAW   = 1'b1;

   // 64-bit lcg multiplier split into two 32-bit halves
   localparam logic [31:0] MULT_HI = 32'h5851_F42D;
   localparam logic [31:0] MULT_LO = 32'h4C95_7F2D;

   localparam int unsigned XS_SHIFT_A = 18;
   localparam int unsigned XS_SHIFT_B = 27;
   localparam int unsigned ROT_SHIFT  = 59;

   // xorshift high bits, then rotate right by the top five state bits
   function automatic logic [31:0] xsh_rr(input logic [63:0] s);
      logic [63:0] mix;
      logic [31:0] xs;
      logic [4:0]  rot;
      logic [63:0] dbl;
      mix = ((s >> XS_SHIFT_A) ^ s) >> XS_SHIFT_B;
      xs  = mix[31:0];
      rot = 5'(s >> ROT_SHIFT);
      dbl = {xs, xs} >> rot;
      return dbl[31:0];
   endfunction

endpackage

// ===== hdl/dspr_step.sv =====
// dspr_step: one pcg generator step on a shared 32x32 multiplier
// uses dspr_pkg for the multiplier constants and the output permutation
`timescale 1ns / 1ps

module dspr_step (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] state_in,
   input  logic [63:0] incr_in,
   output logic        done,
   output logic [63:0] next_state,
   output logic [31:0] out_word
);

   logic [63:0] s_ff, s_in;
   logic [63:0] inc_ff, inc_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] out_ff, out_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;

   // partial products: lo*lo, lo*hi, hi*lo (low word of the last two added into the upper half)
   always_comb begin
      mul_a = (cnt_ff == 2'd2) ? s_ff[63:32] : s_ff[31:0];
      mul_b = (cnt_ff == 2'd1) ? dspr_pkg::MULT_HI : dspr_pkg::MULT_LO;
      prod  = mul_a * mul_b;
   end

   always_comb begin
      s_in    = s_ff;
      inc_in  = inc_ff;
      acc_in  = acc_ff;
      out_in  = out_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         s_in    = state_in;
         inc_in  = incr_in;
         out_in  = dspr_pkg::xsh_rr(state_in);
         cnt_in  = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         case (cnt_ff)
            2'd0:    acc_in = prod;
            2'd1:    acc_in = acc_ff + {prod[31:0], 32'd0};
            2'd2:    acc_in = acc_ff + {prod[31:0], 32'd0};
            default: begin
               acc_in  = acc_ff + inc_ff;
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
         cnt_in = cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      s_ff   <= s_in;
      inc_ff <= inc_in;
      acc_ff <= acc_in;
      out_ff <= out_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done       = done_ff;
   assign next_state = acc_ff;
   assign out_word   = out_ff;

endmodule

// ===== hdl/dspr_div.sv =====
// dspr_div: bit-serial restoring remainder unit, 64-bit operands
// no package dependencies
`timescale 1ns / 1ps

module dspr_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] remainder
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] diff;

   always_comb begin
      trial = {rem_ff, dvd_ff[63]};
      diff  = trial - {1'b0, dvs_ff};
   end

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = 64'd0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit a cycle
         rem_in = diff[64] ? trial[63:0] : diff[63:0];
         dvd_in = {dvd_ff[62:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/dual_stream_pcg_random_range_unit.sv =====
// dual_stream_pcg_random_range_unit: two pcg32 xsh-rr generators with range draws
// depends on dspr_pkg, dspr_step and dspr_div
`timescale 1ns / 1ps

// usage
// - request channel (req_): tuser is the operation, 0 reseeds, 1 draws;
//   tdata carries the seed (bits 63:0) and the inclusive maximum (bits 127:64)
// - result channel (rsp_): one 64-bit value per request, zero after a reseed
// - one request is worked on at a time; req_tready is high only when idle,
//   while an earlier result may still be waiting in the output register
// - generator steps run on the shared 32x32 multiplier, remainders on the
//   bit-serial divider
// - a word draw uses a gen0 output, a full draw pairs a gen0 and a gen1 output;
//   small and large ranges take a threshold remainder, redraw until an output
//   passes it and then take its remainder; a reseed runs 9 helper steps and
//   2 setup steps; the next request is taken once the result has moved to the
//   output register, so requests do not overlap
// - after reset the block reseeds itself with seed zero (req_tready low, no
//   result sent)
// - if the receiver stalls the finished result is held in rsp_tdata and
//   the next result waits in the sequencer until the register frees up

module dual_stream_pcg_random_range_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // seed [63:0], upper_bound [127:64]
   input  logic         req_tuser,   // operation [0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata    // random_value [63:0]
);

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_HELPER     = 4'd1;
   localparam logic [3:0] ST_SEED_STEP  = 4'd2;
   localparam logic [3:0] ST_SETUP      = 4'd3;
   localparam logic [3:0] ST_SETUP_STEP = 4'd4;
   localparam logic [3:0] ST_DRAW       = 4'd5;
   localparam logic [3:0] ST_THR_DIV    = 4'd6;
   localparam logic [3:0] ST_GEN_STEP   = 4'd7;
   localparam logic [3:0] ST_MOD_DIV    = 4'd8;
   localparam logic [3:0] ST_RESULT     = 4'd9;

   localparam logic [1:0] MODE_FULL  = 2'd0;
   localparam logic [1:0] MODE_WORD  = 2'd1;
   localparam logic [1:0] MODE_SMALL = 2'd2;
   localparam logic [1:0] MODE_LARGE = 2'd3;

   logic [3:0]   state_ff, state_in;
   logic [63:0]  seed_ff, seed_in;
   logic [63:0]  max_ff, max_in;
   logic [1:0]   mode_ff, mode_in;
   logic [63:0]  m_ff, m_in;
   logic [63:0]  t_ff, t_in;
   logic [63:0]  r_ff, r_in;
   logic [63:0]  res_ff, res_in;
   logic [63:0]  wst_ff, wst_in;
   logic [63:0]  winc_ff, winc_in;
   logic [255:0] words_ff, words_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic         k_ff, k_in;
   logic         sel_ff, sel_in;
   logic [63:0]  gst_ff [2];
   logic [63:0]  gst_in [2];
   logic [63:0]  ginc_ff [2];
   logic [63:0]  ginc_in [2];
   logic         step_go_ff, step_go_in;
   logic         div_go_ff, div_go_in;
   logic         resp_en_ff, resp_en_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  rsp_data_ff, rsp_data_in;

   logic         step_done;
   logic [63:0]  step_next;
   logic [31:0]  step_out;
   logic [63:0]  step_st;
   logic [63:0]  step_inc;
   logic         div_done;
   logic [63:0]  div_rem;
   logic [63:0]  div_dvd;
   logic [63:0]  setup_a, setup_b, setup_inc;
   logic [63:0]  helper_inc;
   logic [63:0]  full_word;
   logic         req_fire;

   assign req_fire = req_tvalid && req_tready;

   // operand selection for the shared units
   always_comb begin
      if (state_ff == ST_GEN_STEP) begin
         step_st  = gst_ff[sel_ff];
         step_inc = ginc_ff[sel_ff];
      end else begin
         step_st  = wst_ff;
         step_inc = winc_ff;
      end
      if (state_ff == ST_MOD_DIV) begin
         div_dvd = r_ff;
      end else if (mode_ff == MODE_SMALL) begin
         div_dvd = {32'd0, 32'd0 - m_ff[31:0]};
      end else begin
         div_dvd = 64'd0 - m_ff;
      end
   end

   dspr_step u_step (
      .clock      (clock),
      .reset      (reset),
      .start      (step_go_ff),
      .state_in   (step_st),
      .incr_in    (step_inc),
      .done       (step_done),
      .next_state (step_next),
      .out_word   (step_out)
   );

   dspr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go_ff),
      .dividend  (div_dvd),
      .divisor   (m_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      setup_a    = k_ff ? words_ff[127:64] : words_ff[255:192];
      setup_b    = k_ff ? words_ff[63:0]   : words_ff[191:128];
      setup_inc  = {setup_b[62:0], 1'b1};
      helper_inc = {~seed_ff[62:0], 1'b1};
      full_word  = {step_out, r_ff[31:0]};
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      max_in       = max_ff;
      mode_in      = mode_ff;
      m_in         = m_ff;
      t_in         = t_ff;
      r_in         = r_ff;
      res_in       = res_ff;
      wst_in       = wst_ff;
      winc_in      = winc_ff;
      words_in     = words_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      sel_in       = sel_ff;
      gst_in       = gst_ff;
      ginc_in      = ginc_ff;
      step_go_in   = 1'b0;
      div_go_in    = 1'b0;
      resp_en_in   = resp_en_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               seed_in    = req_tdata[63:0];
               max_in     = req_tdata[127:64];
               resp_en_in = 1'b1;
               state_in   = (req_tuser == dspr_pkg::OP_RESEED) ? ST_HELPER : ST_DRAW;
            end
         end
         ST_HELPER: begin
            winc_in    = helper_inc;
            wst_in     = helper_inc + seed_ff;
            cnt_in     = 4'd0;
            step_go_in = 1'b1;
            state_in   = ST_SEED_STEP;
         end
         ST_SEED_STEP: begin
            if (step_done) begin
               wst_in = step_next;
               // first helper output is discarded
               if (cnt_ff != 4'd0) begin
                  words_in = {words_ff[223:0], step_out};
               end
               if (cnt_ff == 4'd8) begin
                  k_in     = 1'b0;
                  state_in = ST_SETUP;
               end else begin
                  cnt_in     = cnt_ff + 4'd1;
                  step_go_in = 1'b1;
               end
            end
         end
         ST_SETUP: begin
            winc_in    = setup_inc;
            wst_in     = setup_inc + setup_a;
            step_go_in = 1'b1;
            state_in   = ST_SETUP_STEP;
         end
         ST_SETUP_STEP: begin
            if (step_done) begin
               gst_in[k_ff]  = step_next;
               ginc_in[k_ff] = winc_ff;
               if (k_ff) begin
                  res_in   = 64'd0;
                  state_in = ST_RESULT;
               end else begin
                  k_in     = 1'b1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_DRAW: begin
            sel_in = 1'b0;
            if (max_ff == 64'hFFFF_FFFF_FFFF_FFFF) begin
               mode_in    = MODE_FULL;
               step_go_in = 1'b1;
               state_in   = ST_GEN_STEP;
            end else if (max_ff == 64'h0000_0000_FFFF_FFFF) begin
               mode_in    = MODE_WORD;
               step_go_in = 1'b1;
               state_in   = ST_GEN_STEP;
            end else if (max_ff < 64'h0000_0000_FFFF_FFFF) begin
               mode_in   = MODE_SMALL;
               m_in      = {32'd0, max_ff[31:0] + 32'd1};
               div_go_in = 1'b1;
               state_in  = ST_THR_DIV;
            end else begin
               mode_in   = MODE_LARGE;
               m_in      = max_ff + 64'd1;
               div_go_in = 1'b1;
               state_in  = ST_THR_DIV;
            end
         end
         ST_THR_DIV: begin
            if (div_done) begin
               t_in       = div_rem;
               sel_in     = 1'b0;
               step_go_in = 1'b1;
               state_in   = ST_GEN_STEP;
            end
         end
         ST_GEN_STEP: begin
            if (step_done) begin
               gst_in[sel_ff] = step_next;
               case (mode_ff)
                  MODE_WORD: begin
                     res_in   = {32'd0, step_out};
                     state_in = ST_RESULT;
                  end
                  MODE_SMALL: begin
                     if (step_out >= t_ff[31:0]) begin
                        r_in      = {32'd0, step_out};
                        div_go_in = 1'b1;
                        state_in  = ST_MOD_DIV;
                     end else begin
                        sel_in     = !sel_ff;
                        step_go_in = 1'b1;
                     end
                  end
                  default: begin
                     // full and large ranges pair a gen0 and a gen1 output
                     if (!sel_ff) begin
                        r_in       = {r_ff[63:32], step_out};
                        sel_in     = 1'b1;
                        step_go_in = 1'b1;
                     end else if (mode_ff == MODE_FULL) begin
                        res_in   = full_word;
                        state_in = ST_RESULT;
                     end else if (full_word >= t_ff) begin
                        r_in      = full_word;
                        div_go_in = 1'b1;
                        state_in  = ST_MOD_DIV;
                     end else begin
                        sel_in     = 1'b0;
                        step_go_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_MOD_DIV: begin
            if (div_done) begin
               res_in   = div_rem;
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!resp_en_ff) begin
               // start-up reseed sends nothing
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      max_ff      <= max_in;
      mode_ff     <= mode_in;
      m_ff        <= m_in;
      t_ff        <= t_in;
      r_ff        <= r_in;
      res_ff      <= res_in;
      wst_ff      <= wst_in;
      winc_ff     <= winc_in;
      words_ff    <= words_in;
      cnt_ff      <= cnt_in;
      k_ff        <= k_in;
      sel_ff      <= sel_in;
      gst_ff      <= gst_in;
      ginc_ff     <= ginc_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_HELPER;
         seed_ff      <= 64'd0;
         step_go_ff   <= 1'b0;
         div_go_ff    <= 1'b0;
         resp_en_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         step_go_ff   <= step_go_in;
         div_go_ff    <= div_go_in;
         resp_en_ff   <= resp_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
